>>> rtl/core/crff_pkg.sv
`timescale 1ns / 1ps

package crff_pkg;

    localparam int CRFF_CORDIC_STAGES = 16;

    localparam int CX_W = 34;
    localparam int Z_W  = 33;

    localparam logic [30:0] HALF_PI_Q30     = 31'd1686629713;
    localparam logic [30:0] ONE_Q30         = 31'd1073741824;
    localparam logic [30:0] CORDIC_GAIN_Q30 = 31'd652032874;
    localparam logic [14:0] FULL_Q14        = 15'd16384;

    localparam logic [1:0] ZONE_OUT    = 2'd0;
    localparam logic [1:0] ZONE_CORE   = 2'd1;
    localparam logic [1:0] ZONE_MARGIN = 2'd2;

    localparam logic [1:0] CFG_CRITICAL_RADIUS = 2'd0;
    localparam logic [1:0] CFG_MARGIN_DISTANCE = 2'd1;
    localparam logic [1:0] CFG_STOP_DISTANCE   = 2'd2;

    localparam logic [15:0] RST_CRITICAL_RADIUS = 16'd256;
    localparam logic [15:0] RST_MARGIN_DISTANCE = 16'd256;
    localparam logic [15:0] RST_STOP_DISTANCE   = 16'd128;

    function automatic logic [29:0] atan_q30(input int idx);
        logic [29:0] v;
        case (idx)
            0:       v = 30'd843314857;
            1:       v = 30'd497837829;
            2:       v = 30'd263043837;
            3:       v = 30'd133525159;
            4:       v = 30'd67021687;
            5:       v = 30'd33543516;
            6:       v = 30'd16775851;
            7:       v = 30'd8388437;
            8:       v = 30'd4194283;
            9:       v = 30'd2097149;
            10:      v = 30'd1048576;
            11:      v = 30'd524288;
            12:      v = 30'd262144;
            13:      v = 30'd131072;
            14:      v = 30'd65536;
            15:      v = 30'd32768;
            16:      v = 30'd16384;
            17:      v = 30'd8192;
            18:      v = 30'd4096;
            19:      v = 30'd2048;
            20:      v = 30'd1024;
            21:      v = 30'd512;
            22:      v = 30'd256;
            23:      v = 30'd128;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/core/crff_sqrt_cell.sv
`timescale 1ns / 1ps

module crff_sqrt_cell #(
    parameter int W  = 24,
    parameter int SW = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [SW-1:0]   i_side,
    input  logic [W:0]      i_rem,
    input  logic [W-1:0]    i_root,
    input  logic [2*W-1:0]  i_rad,
    output logic            o_valid,
    output logic [SW-1:0]   o_side,
    output logic [W:0]      o_rem,
    output logic [W-1:0]    o_root,
    output logic [2*W-1:0]  o_rad
);

    logic [W+2:0]   w_pre;
    logic [W+2:0]   w_trial;
    logic [W+2:0]   w_diff;
    logic           w_ge;
    logic [W:0]     n_rem;
    logic [W-1:0]   n_root;
    logic [2*W-1:0] n_rad;

    logic           r_valid;
    logic [SW-1:0]  r_side;
    logic [W:0]     r_rem;
    logic [W-1:0]   r_root;
    logic [2*W-1:0] r_rad;

    always_comb begin
        w_pre   = {i_rem, i_rad[2*W-1 -: 2]};
        w_trial = {1'b0, i_root, 2'b01};
        w_diff  = w_pre - w_trial;
        w_ge    = (w_pre >= w_trial);
        n_rem   = w_ge ? w_diff[W:0] : w_pre[W:0];
        n_root  = {i_root[W-2:0], w_ge};
        n_rad   = {i_rad[2*W-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_rem  <= n_rem;
            r_root <= n_root;
            r_rad  <= n_rad;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_rad   = r_rad;

endmodule

>>> rtl/core/crff_div_cell.sv
`timescale 1ns / 1ps

module crff_div_cell #(
    parameter int DW    = 16,
    parameter int QW    = 16,
    parameter int LANES = 1,
    parameter int SW    = 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [SW-1:0]              i_side,
    input  logic [DW-1:0]              i_div,
    input  logic [LANES-1:0][DW-1:0]   i_rem,
    input  logic [LANES-1:0][QW-1:0]   i_num,
    input  logic [LANES-1:0][QW-1:0]   i_quot,
    output logic                       o_valid,
    output logic [SW-1:0]              o_side,
    output logic [DW-1:0]              o_div,
    output logic [LANES-1:0][DW-1:0]   o_rem,
    output logic [LANES-1:0][QW-1:0]   o_num,
    output logic [LANES-1:0][QW-1:0]   o_quot
);

    logic [LANES-1:0][DW:0]   w_sh;
    logic [LANES-1:0][DW:0]   w_diff;
    logic [LANES-1:0]         w_ge;
    logic [LANES-1:0][DW-1:0] n_rem;
    logic [LANES-1:0][QW-1:0] n_num;
    logic [LANES-1:0][QW-1:0] n_quot;

    logic                     r_valid;
    logic [SW-1:0]            r_side;
    logic [DW-1:0]            r_div;
    logic [LANES-1:0][DW-1:0] r_rem;
    logic [LANES-1:0][QW-1:0] r_num;
    logic [LANES-1:0][QW-1:0] r_quot;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_sh[l]   = {i_rem[l], i_num[l][QW-1]};
            w_diff[l] = w_sh[l] - {1'b0, i_div};
            w_ge[l]   = (w_sh[l] >= {1'b0, i_div});
            n_rem[l]  = w_ge[l] ? w_diff[l][DW-1:0] : w_sh[l][DW-1:0];
            n_num[l]  = {i_num[l][QW-2:0], 1'b0};
            n_quot[l] = {i_quot[l][QW-2:0], w_ge[l]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_div  <= i_div;
            r_rem  <= n_rem;
            r_num  <= n_num;
            r_quot <= n_quot;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_div   = r_div;
    assign o_rem   = r_rem;
    assign o_num   = r_num;
    assign o_quot  = r_quot;

endmodule

>>> rtl/core/crff_cordic_cell.sv
`timescale 1ns / 1ps

module crff_cordic_cell import crff_pkg::*; #(
    parameter int STAGE = 0,
    parameter int SW    = 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [SW-1:0]          i_side,
    input  logic signed [CX_W-1:0] i_cx,
    input  logic signed [CX_W-1:0] i_cy,
    input  logic signed [Z_W-1:0]  i_z,
    output logic                   o_valid,
    output logic [SW-1:0]          o_side,
    output logic signed [CX_W-1:0] o_cx,
    output logic signed [CX_W-1:0] o_cy,
    output logic signed [Z_W-1:0]  o_z
);

    localparam logic signed [Z_W-1:0] ATAN = Z_W'(atan_q30(STAGE));

    logic signed [CX_W-1:0] w_sx;
    logic signed [CX_W-1:0] w_sy;
    logic signed [CX_W-1:0] n_cx;
    logic signed [CX_W-1:0] n_cy;
    logic signed [Z_W-1:0]  n_z;

    logic                   r_valid;
    logic [SW-1:0]          r_side;
    logic signed [CX_W-1:0] r_cx;
    logic signed [CX_W-1:0] r_cy;
    logic signed [Z_W-1:0]  r_z;

    always_comb begin
        w_sx = i_cx >>> STAGE;
        w_sy = i_cy >>> STAGE;
        if (!i_z[Z_W-1]) begin
            n_cx = i_cx - w_sy;
            n_cy = i_cy + w_sx;
            n_z  = i_z - ATAN;
        end else begin
            n_cx = i_cx + w_sy;
            n_cy = i_cy - w_sx;
            n_z  = i_z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_cx   <= n_cx;
            r_cy   <= n_cy;
            r_z    <= n_z;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_cx    = r_cx;
    assign o_cy    = r_cy;
    assign o_z     = r_z;

endmodule

>>> rtl/core/capsule_repulsive_force_field.sv
`timescale 1ns / 1ps

// Repulsive force from one obstacle point per request. A request on the slave
// stream carries point_x, point_y and point_z; the master stream returns the
// force vector in tdata and the zone code in tuser, one result per request.
// Configuration registers are written through the cfg channel, which is always
// ready; they must only change while no request is in flight.
// The datapath is a chain of cells: a root cell per result bit for the point
// norm and for the capsule distance, a divider cell per quotient bit for the
// ramp position and for the three components, and a rotation cell per CORDIC
// stage. One request is taken every cycle while the receiver does not stall.
// Reset clears all valid flags and loads the register defaults; the first
// request can be taken in the cycle after reset is released.
// When the receiver stalls with a result pending, the whole chain holds and
// o_s_tready drops until the pending result is taken.
module capsule_repulsive_force_field import crff_pkg::*; #(
    parameter int CORDIC_STAGES = CRFF_CORDIC_STAGES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // point_x, point_y, point_z
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // force_x, force_y, force_z
    output logic [1:0]  o_m_tuser,   // zone
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data
);

    localparam int SN_W = 30;
    localparam int SD_W = 24;
    localparam int D1_Q = 16;
    localparam int D2_D = 30;
    localparam int D2_Q = 15;

    typedef struct packed {
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] pz;
        logic [1:0]         zone;
    } t_item;

    typedef struct packed {
        t_item       item;
        logic [31:0] dsq;
    } t_sn_side;

    typedef struct packed {
        t_item       item;
        logic [29:0] n;
    } t_pn_side;

    typedef struct packed {
        t_pn_side pn;
        logic     ovf;
    } t_d1_side;

    typedef struct packed {
        t_item      item;
        logic [2:0] ovf;
    } t_d2_side;

    localparam int SN_SW = $bits(t_sn_side);
    localparam int PN_SW = $bits(t_pn_side);
    localparam int D1_SW = $bits(t_d1_side);
    localparam int D2_SW = $bits(t_d2_side);

    logic        w_en;
    logic [15:0] r_crit;
    logic [15:0] r_margin;
    logic [15:0] r_stop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crit   <= RST_CRITICAL_RADIUS;
            r_margin <= RST_MARGIN_DISTANCE;
            r_stop   <= RST_STOP_DISTANCE;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                CFG_CRITICAL_RADIUS: r_crit   <= i_cfg_data;
                CFG_MARGIN_DISTANCE: r_margin <= i_cfg_data;
                CFG_STOP_DISTANCE:   r_stop   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front stages: offset from the capsule axis, squares, sums, zone.
    logic signed [15:0] w_in_px, w_in_py, w_in_pz;
    logic signed [16:0] n_a_dx;
    logic               r_a_valid;
    logic signed [15:0] r_a_px, r_a_py, r_a_pz;
    logic signed [16:0] r_a_dx;

    assign w_in_px = i_s_tdata[15:0];
    assign w_in_py = i_s_tdata[31:16];
    assign w_in_pz = i_s_tdata[47:32];

    always_comb begin
        if (w_in_px[15]) begin
            n_a_dx = 17'(w_in_px);
        end else if (17'(w_in_px) > $signed({1'b0, r_stop})) begin
            n_a_dx = 17'(w_in_px) - $signed({1'b0, r_stop});
        end else begin
            n_a_dx = '0;
        end
    end

    logic signed [33:0] w_dxsq;
    logic signed [31:0] w_pxsq, w_pysq, w_pzsq;
    logic [31:0]        w_rr;
    logic [16:0]        w_outer;
    logic [33:0]        w_oo;
    logic               r_b_valid;
    t_item              r_b_item;
    logic [30:0]        r_b_dxsq, r_b_pxsq, r_b_pysq, r_b_pzsq;
    logic [31:0]        r_b_rr;
    logic [33:0]        r_b_oo;

    assign w_dxsq  = 34'(r_a_dx) * 34'(r_a_dx);
    assign w_pxsq  = 32'(r_a_px) * 32'(r_a_px);
    assign w_pysq  = 32'(r_a_py) * 32'(r_a_py);
    assign w_pzsq  = 32'(r_a_pz) * 32'(r_a_pz);
    assign w_rr    = 32'(r_crit) * 32'(r_crit);
    assign w_outer = 17'(r_crit) + 17'(r_margin);
    assign w_oo    = 34'(w_outer) * 34'(w_outer);

    logic        r_c_valid;
    t_item       r_c_item;
    logic [31:0] r_c_dsq, r_c_nsq, r_c_rr;
    logic [33:0] r_c_oo;

    logic [1:0]  n_d_zone;
    logic        r_d_valid;
    t_item       r_d_item;
    logic [31:0] r_d_dsq, r_d_nsq;

    always_comb begin
        if (r_c_dsq <= r_c_rr) begin
            n_d_zone = ZONE_CORE;
        end else if (r_margin != 16'd0 && {2'b00, r_c_dsq} < r_c_oo) begin
            n_d_zone = ZONE_MARGIN;
        end else begin
            n_d_zone = ZONE_OUT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= i_s_tvalid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_px <= w_in_px;
            r_a_py <= w_in_py;
            r_a_pz <= w_in_pz;
            r_a_dx <= n_a_dx;

            r_b_item <= '{px: r_a_px, py: r_a_py, pz: r_a_pz, zone: ZONE_OUT};
            r_b_dxsq <= w_dxsq[30:0];
            r_b_pxsq <= w_pxsq[30:0];
            r_b_pysq <= w_pysq[30:0];
            r_b_pzsq <= w_pzsq[30:0];
            r_b_rr   <= w_rr;
            r_b_oo   <= w_oo;

            r_c_item <= r_b_item;
            r_c_dsq  <= 32'(r_b_dxsq) + 32'(r_b_pysq);
            r_c_nsq  <= 32'(r_b_pxsq) + 32'(r_b_pysq) + 32'(r_b_pzsq);
            r_c_rr   <= r_b_rr;
            r_c_oo   <= r_b_oo;

            r_d_item <= '{px: r_c_item.px, py: r_c_item.py, pz: r_c_item.pz,
                          zone: n_d_zone};
            r_d_dsq  <= r_c_dsq;
            r_d_nsq  <= r_c_nsq;
        end
    end

    // Norm of the point: one root cell per result bit.
    logic [SN_W:0]     w_sn_rem  [0:SN_W];
    logic [SN_W-1:0]   w_sn_root [0:SN_W];
    logic [2*SN_W-1:0] w_sn_rad  [0:SN_W];
    logic              w_sn_vld  [0:SN_W];
    logic [SN_SW-1:0]  w_sn_side [0:SN_W];

    assign w_sn_rem[0]  = '0;
    assign w_sn_root[0] = '0;
    assign w_sn_rad[0]  = {r_d_nsq, 28'd0};
    assign w_sn_vld[0]  = r_d_valid;
    assign w_sn_side[0] = t_sn_side'{item: r_d_item, dsq: r_d_dsq};

    for (genvar g = 0; g < SN_W; g++) begin : g_sn
        crff_sqrt_cell #(.W(SN_W), .SW(SN_SW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_sn_vld[g]),
            .i_side  (w_sn_side[g]),
            .i_rem   (w_sn_rem[g]),
            .i_root  (w_sn_root[g]),
            .i_rad   (w_sn_rad[g]),
            .o_valid (w_sn_vld[g+1]),
            .o_side  (w_sn_side[g+1]),
            .o_rem   (w_sn_rem[g+1]),
            .o_root  (w_sn_root[g+1]),
            .o_rad   (w_sn_rad[g+1])
        );
    end

    t_sn_side w_sn_out;
    assign w_sn_out = w_sn_side[SN_W];

    // Planar distance to the capsule axis.
    logic [SD_W:0]     w_sd_rem  [0:SD_W];
    logic [SD_W-1:0]   w_sd_root [0:SD_W];
    logic [2*SD_W-1:0] w_sd_rad  [0:SD_W];
    logic              w_sd_vld  [0:SD_W];
    logic [PN_SW-1:0]  w_sd_side [0:SD_W];

    assign w_sd_rem[0]  = '0;
    assign w_sd_root[0] = '0;
    assign w_sd_rad[0]  = {w_sn_out.dsq, 16'd0};
    assign w_sd_vld[0]  = w_sn_vld[SN_W];
    assign w_sd_side[0] = t_pn_side'{item: w_sn_out.item, n: w_sn_root[SN_W]};

    for (genvar g = 0; g < SD_W; g++) begin : g_sd
        crff_sqrt_cell #(.W(SD_W), .SW(PN_SW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_sd_vld[g]),
            .i_side  (w_sd_side[g]),
            .i_rem   (w_sd_rem[g]),
            .i_root  (w_sd_root[g]),
            .i_rad   (w_sd_rad[g]),
            .o_valid (w_sd_vld[g+1]),
            .o_side  (w_sd_side[g+1]),
            .o_rem   (w_sd_rem[g+1]),
            .o_root  (w_sd_root[g+1]),
            .o_rad   (w_sd_rad[g+1])
        );
    end

    // Depth into the margin and set-up of the ramp divider.
    logic [23:0] w_rf;
    logic [23:0] n_e_df;
    logic        r_e_valid;
    t_pn_side    r_e_side;
    logic [15:0] r_e_rem;
    logic [15:0] r_e_num;
    logic        r_e_ovf;

    assign w_rf   = {r_crit, 8'd0};
    assign n_e_df = (w_sd_root[SD_W] > w_rf) ? (w_sd_root[SD_W] - w_rf) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (w_en) begin
            r_e_valid <= w_sd_vld[SD_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_side <= w_sd_side[SD_W];
            r_e_rem  <= n_e_df[23:8];
            r_e_num  <= {n_e_df[7:0], 8'd0};
            r_e_ovf  <= (n_e_df[23:8] >= r_margin);
        end
    end

    logic [0:0][15:0]     w_d1_rem  [0:D1_Q];
    logic [0:0][D1_Q-1:0] w_d1_num  [0:D1_Q];
    logic [0:0][D1_Q-1:0] w_d1_quot [0:D1_Q];
    logic [15:0]          w_d1_div  [0:D1_Q];
    logic                 w_d1_vld  [0:D1_Q];
    logic [D1_SW-1:0]     w_d1_side [0:D1_Q];

    assign w_d1_rem[0]  = r_e_rem;
    assign w_d1_num[0]  = r_e_num;
    assign w_d1_quot[0] = '0;
    assign w_d1_div[0]  = r_margin;
    assign w_d1_vld[0]  = r_e_valid;
    assign w_d1_side[0] = t_d1_side'{pn: r_e_side, ovf: r_e_ovf};

    for (genvar g = 0; g < D1_Q; g++) begin : g_d1
        crff_div_cell #(.DW(16), .QW(D1_Q), .LANES(1), .SW(D1_SW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_d1_vld[g]),
            .i_side  (w_d1_side[g]),
            .i_div   (w_d1_div[g]),
            .i_rem   (w_d1_rem[g]),
            .i_num   (w_d1_num[g]),
            .i_quot  (w_d1_quot[g]),
            .o_valid (w_d1_vld[g+1]),
            .o_side  (w_d1_side[g+1]),
            .o_div   (w_d1_div[g+1]),
            .o_rem   (w_d1_rem[g+1]),
            .o_num   (w_d1_num[g+1]),
            .o_quot  (w_d1_quot[g+1])
        );
    end

    // Ramp position to angle.
    t_d1_side    w_d1_out;
    logic [15:0] w_t;
    logic [46:0] w_angp;
    logic        r_f_valid;
    t_pn_side    r_f_side;
    logic [30:0] r_f_ang;

    assign w_d1_out = w_d1_side[D1_Q];
    assign w_t      = w_d1_out.ovf ? 16'hFFFF : w_d1_quot[D1_Q][0];
    assign w_angp   = 47'(w_t) * 47'(HALF_PI_Q30);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (w_en) begin
            r_f_valid <= w_d1_vld[D1_Q];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_side <= w_d1_out.pn;
            r_f_ang  <= w_angp[46:16];
        end
    end

    logic signed [CX_W-1:0] w_cx   [0:CORDIC_STAGES];
    logic signed [CX_W-1:0] w_cy   [0:CORDIC_STAGES];
    logic signed [Z_W-1:0]  w_z    [0:CORDIC_STAGES];
    logic                   w_c_vld  [0:CORDIC_STAGES];
    logic [PN_SW-1:0]       w_c_side [0:CORDIC_STAGES];

    assign w_cx[0]     = CX_W'(CORDIC_GAIN_Q30);
    assign w_cy[0]     = '0;
    assign w_z[0]      = Z_W'(r_f_ang);
    assign w_c_vld[0]  = r_f_valid;
    assign w_c_side[0] = r_f_side;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
        crff_cordic_cell #(.STAGE(g), .SW(PN_SW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_c_vld[g]),
            .i_side  (w_c_side[g]),
            .i_cx    (w_cx[g]),
            .i_cy    (w_cy[g]),
            .i_z     (w_z[g]),
            .o_valid (w_c_vld[g+1]),
            .o_side  (w_c_side[g+1]),
            .o_cx    (w_cx[g+1]),
            .o_cy    (w_cy[g+1]),
            .o_z     (w_z[g+1])
        );
    end

    // Magnitude from the sine in the margin zone; full scale in the other zones.
    t_pn_side               w_c_out;
    logic signed [CX_W-1:0] w_cy_end;
    logic [30:0]            w_sin;
    logic [31:0]            w_magw;
    logic [14:0]            n_g_mag;
    logic                   r_g_valid;
    t_pn_side               r_g_side;
    logic [14:0]            r_g_mag;

    assign w_c_out  = w_c_side[CORDIC_STAGES];
    assign w_cy_end = w_cy[CORDIC_STAGES];

    always_comb begin
        if (w_cy_end < 0) begin
            w_sin = '0;
        end else if (w_cy_end > $signed(CX_W'(ONE_Q30))) begin
            w_sin = ONE_Q30;
        end else begin
            w_sin = w_cy_end[30:0];
        end
        w_magw = 32'(ONE_Q30) - 32'(w_sin) + 32'd32768;
        if (w_c_out.item.zone == ZONE_MARGIN) begin
            n_g_mag = w_magw[30:16];
        end else begin
            n_g_mag = FULL_Q14;
        end
    end

    // Scaled components and set-up of the component dividers.
    logic [2:0][15:0]  w_ap;
    logic [2:0][30:0]  w_prod;
    logic              r_h_valid;
    t_pn_side          r_h_side;
    logic [2:0][29:0]  r_h_prod;

    always_comb begin
        w_ap[0] = r_g_side.item.px[15] ? 16'(-r_g_side.item.px) : r_g_side.item.px;
        w_ap[1] = r_g_side.item.py[15] ? 16'(-r_g_side.item.py) : r_g_side.item.py;
        w_ap[2] = r_g_side.item.pz[15] ? 16'(-r_g_side.item.pz) : r_g_side.item.pz;
        for (int l = 0; l < 3; l++) begin
            w_prod[l] = 31'(r_g_mag) * 31'(w_ap[l]);
        end
    end

    logic [2:0][43:0]   w_num;
    logic [2:0]         w_i_ovf;
    logic               r_i_valid;
    t_d2_side           r_i_side;
    logic [29:0]        r_i_n;
    logic [2:0][29:0]   r_i_rem;
    logic [2:0][D2_Q-1:0] r_i_num;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_num[l]   = {r_h_prod[l], 14'd0} + 44'(r_h_side.n[29:1]);
            w_i_ovf[l] = ({1'b0, w_num[l][43:15]} >= r_h_side.n);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid <= 1'b0;
            r_h_valid <= 1'b0;
            r_i_valid <= 1'b0;
        end else if (w_en) begin
            r_g_valid <= w_c_vld[CORDIC_STAGES];
            r_h_valid <= r_g_valid;
            r_i_valid <= r_h_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_g_side <= w_c_out;
            r_g_mag  <= n_g_mag;

            r_h_side <= r_g_side;
            for (int l = 0; l < 3; l++) begin
                r_h_prod[l] <= w_prod[l][29:0];
            end

            r_i_side <= '{item: r_h_side.item, ovf: w_i_ovf};
            r_i_n    <= r_h_side.n;
            for (int l = 0; l < 3; l++) begin
                r_i_rem[l] <= {1'b0, w_num[l][43:15]};
                r_i_num[l] <= w_num[l][14:0];
            end
        end
    end

    logic [2:0][D2_D-1:0] w_d2_rem  [0:D2_Q];
    logic [2:0][D2_Q-1:0] w_d2_num  [0:D2_Q];
    logic [2:0][D2_Q-1:0] w_d2_quot [0:D2_Q];
    logic [D2_D-1:0]      w_d2_div  [0:D2_Q];
    logic                 w_d2_vld  [0:D2_Q];
    logic [D2_SW-1:0]     w_d2_side [0:D2_Q];

    assign w_d2_rem[0]  = r_i_rem;
    assign w_d2_num[0]  = r_i_num;
    assign w_d2_quot[0] = '0;
    assign w_d2_div[0]  = r_i_n;
    assign w_d2_vld[0]  = r_i_valid;
    assign w_d2_side[0] = r_i_side;

    for (genvar g = 0; g < D2_Q; g++) begin : g_d2
        crff_div_cell #(.DW(D2_D), .QW(D2_Q), .LANES(3), .SW(D2_SW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_d2_vld[g]),
            .i_side  (w_d2_side[g]),
            .i_div   (w_d2_div[g]),
            .i_rem   (w_d2_rem[g]),
            .i_num   (w_d2_num[g]),
            .i_quot  (w_d2_quot[g]),
            .o_valid (w_d2_vld[g+1]),
            .o_side  (w_d2_side[g+1]),
            .o_div   (w_d2_div[g+1]),
            .o_rem   (w_d2_rem[g+1]),
            .o_num   (w_d2_num[g+1]),
            .o_quot  (w_d2_quot[g+1])
        );
    end

    // Output register.
    t_d2_side                 w_d2_out;
    logic signed [2:0][15:0]  w_p;
    logic                     w_pzero;
    logic [2:0][14:0]         w_q;
    logic [2:0][15:0]         w_qe;
    logic [2:0][15:0]         n_o_force;
    logic                     r_o_valid;
    logic [2:0][15:0]         r_o_force;
    logic [1:0]               r_o_zone;

    assign w_d2_out = w_d2_side[D2_Q];
    assign w_p[0]   = w_d2_out.item.px;
    assign w_p[1]   = w_d2_out.item.py;
    assign w_p[2]   = w_d2_out.item.pz;
    assign w_pzero  = (w_p[0] == 16'd0) && (w_p[1] == 16'd0) && (w_p[2] == 16'd0);

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (w_d2_out.ovf[l] || w_d2_quot[D2_Q][l] > FULL_Q14) begin
                w_q[l] = FULL_Q14;
            end else begin
                w_q[l] = w_d2_quot[D2_Q][l];
            end
            w_qe[l] = {1'b0, w_q[l]};
            if (w_pzero || w_d2_out.item.zone == ZONE_OUT) begin
                n_o_force[l] = '0;
            end else if (!w_p[l][15] && w_p[l] != 16'd0) begin
                n_o_force[l] = -w_qe[l];
            end else begin
                n_o_force[l] = w_qe[l];
            end
        end
    end

    assign w_en = !r_o_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_o_valid <= w_d2_vld[D2_Q];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_force <= n_o_force;
            r_o_zone  <= w_d2_out.item.zone;
        end
    end

    assign o_s_tready = w_en;
    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {r_o_force[2], r_o_force[1], r_o_force[0]};
    assign o_m_tuser  = r_o_zone;

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_zone == ZONE_OUT |-> o_m_tdata == 48'd0)
        else $error("nonzero force outside the field");

    a_force_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> ($signed(r_o_force[0]) <= 16384 && $signed(r_o_force[0]) >= -16384
                    && $signed(r_o_force[1]) <= 16384 && $signed(r_o_force[1]) >= -16384
                    && $signed(r_o_force[2]) <= 16384 && $signed(r_o_force[2]) >= -16384))
        else $error("force component out of range");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable({r_a_valid, r_d_valid, r_e_valid, r_f_valid, r_g_valid, r_i_valid}))
        else $error("pipeline moved during a stall");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_o_valid && !r_a_valid)
        else $error("valid flags not cleared by reset");

endmodule
